>>> sv/sfr_pkg.sv
package sfr_pkg;

  localparam int PAYLOAD_DEPTH = 16;
  localparam int PAY_AW = $clog2(PAYLOAD_DEPTH);
  localparam int MEM_DEPTH = 2 * PAYLOAD_DEPTH;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] PAD_BYTE = 8'h55;
  localparam logic [7:0] END_BYTE = 8'h55;
  localparam logic [7:0] LEN_MASK = 8'h0F;
  localparam logic [15:0] SUM_INIT = 16'h00FF;
  localparam logic [1:0] HDR_RUN_FULL = 2'd2;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_ID = 3'd1,
    PH_CTRL = 3'd2,
    PH_PAY = 3'd3,
    PH_CKH = 3'd4,
    PH_CKL = 3'd5,
    PH_END = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_FETCH = 2'd1,
    BK_SHOW = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [7:0] ident;
    logic [7:0] ctrl;
  } desc_t;

  typedef struct packed {
    logic en;
    logic bank;
    logic [PAY_AW-1:0] addr;
    logic [7:0] data;
  } mem_wr_t;

endpackage

>>> sv/sfr_front.sv
module sfr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_stall,
  output sfr_pkg::mem_wr_t mem_wr,
  output logic            push,
  output sfr_pkg::desc_t  push_desc
);
  import sfr_pkg::*;

  logic [1:0] header_run_r, header_run_nxt;
  phase_t phase_r, phase_nxt;
  logic [7:0] ident_r, ident_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [3:0] bytes_left_r, bytes_left_nxt;
  logic [PAY_AW-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [15:0] sum_low_r, sum_low_nxt;
  logic [15:0] sum_high_r, sum_high_nxt;
  logic [7:0] check_hi_r, check_hi_nxt;
  logic wr_bank_r, wr_bank_nxt;

  logic accept;
  logic in_frame_byte;
  logic [15:0] base_low, base_high, add_low, add_high;
  logic [8:0] fold_lo, fold_hi;
  logic [15:0] fold_sum;

  assign accept = in_valid && !in_stall;
  // byte after two header bytes is handled by the header logic alone
  assign in_frame_byte = accept && (header_run_r != HDR_RUN_FULL);

  // running fletcher sums, restarted on the id byte
  assign base_low = (phase_r == PH_ID) ? SUM_INIT : sum_low_r;
  assign base_high = (phase_r == PH_ID) ? SUM_INIT : sum_high_r;
  assign add_low = base_low + {8'h00, in_byte};
  assign add_high = base_high + add_low;

  assign fold_lo = {1'b0, sum_low_r[7:0]} + {1'b0, sum_low_r[15:8]};
  assign fold_hi = {1'b0, sum_high_r[7:0]} + {1'b0, sum_high_r[15:8]};
  // carry of the low fold lands on bit 8, overlapping the high fold
  assign fold_sum = {fold_hi[7:0], 8'h00} | {7'h00, fold_lo};

  always_comb begin
    header_run_nxt = header_run_r;
    phase_nxt = phase_r;
    ident_nxt = ident_r;
    ctrl_nxt = ctrl_r;
    bytes_left_nxt = bytes_left_r;
    pay_cnt_nxt = pay_cnt_r;
    sum_low_nxt = sum_low_r;
    sum_high_nxt = sum_high_r;
    check_hi_nxt = check_hi_r;
    wr_bank_nxt = wr_bank_r;
    if (accept) begin
      if (header_run_r == HDR_RUN_FULL) begin
        header_run_nxt = 2'd0;
        if (in_byte == HDR_BYTE) begin
          phase_nxt = PH_ID;
        end else if (in_byte != PAD_BYTE) begin
          phase_nxt = PH_SEARCH;
        end
      end else begin
        header_run_nxt = (in_byte == HDR_BYTE) ? header_run_r + 2'd1 : 2'd0;
        case (phase_r)
          PH_ID: begin
            ident_nxt = in_byte;
            pay_cnt_nxt = '0;
            sum_low_nxt = add_low;
            sum_high_nxt = add_high;
            phase_nxt = PH_CTRL;
          end
          PH_CTRL: begin
            ctrl_nxt = in_byte;
            bytes_left_nxt = in_byte[3:0];
            sum_low_nxt = add_low;
            sum_high_nxt = add_high;
            phase_nxt = (in_byte[3:0] != 4'd0) ? PH_PAY : PH_CKH;
          end
          PH_PAY: begin
            pay_cnt_nxt = pay_cnt_r + PAY_AW'(1);
            sum_low_nxt = add_low;
            sum_high_nxt = add_high;
            bytes_left_nxt = bytes_left_r - 4'd1;
            if (bytes_left_r == 4'd1) begin
              phase_nxt = PH_CKH;
            end
          end
          PH_CKH: begin
            check_hi_nxt = in_byte;
            phase_nxt = PH_CKL;
          end
          PH_CKL: begin
            phase_nxt = ({check_hi_r, in_byte} == fold_sum) ? PH_END : PH_SEARCH;
          end
          PH_END: begin
            if (in_byte == END_BYTE) begin
              wr_bank_nxt = !wr_bank_r;
            end
            phase_nxt = PH_SEARCH;
          end
          default: begin
            phase_nxt = PH_SEARCH;
          end
        endcase
      end
    end
  end

  always_comb begin
    push = in_frame_byte && (phase_r == PH_END) && (in_byte == END_BYTE);
    push_desc.ident = ident_r;
    push_desc.ctrl = ctrl_r;
    mem_wr.en = in_frame_byte && (phase_r == PH_PAY);
    mem_wr.bank = wr_bank_r;
    mem_wr.addr = pay_cnt_r;
    mem_wr.data = in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_run_r <= 2'd0;
      phase_r <= PH_SEARCH;
      wr_bank_r <= 1'b0;
    end else begin
      header_run_r <= header_run_nxt;
      phase_r <= phase_nxt;
      wr_bank_r <= wr_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ident_r <= ident_nxt;
    ctrl_r <= ctrl_nxt;
    bytes_left_r <= bytes_left_nxt;
    pay_cnt_r <= pay_cnt_nxt;
    sum_low_r <= sum_low_nxt;
    sum_high_r <= sum_high_nxt;
    check_hi_r <= check_hi_nxt;
  end

  header_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    header_run_r != 2'd3)
    else $error("header run counter out of range");

  push_toggles_bank: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> wr_bank_r != $past(wr_bank_r))
    else $error("write bank did not flip on frame commit");

endmodule

>>> sv/sfr_queue.sv
module sfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfr_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output sfr_pkg::desc_t head
);
  import sfr_pkg::*;

  desc_t slot_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_full = (count_r == 2'd2);
  assign head = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("frame committed into a full queue");

endmodule

>>> sv/sfr_back.sv
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::mem_wr_t mem_wr,
  input  logic             q_valid,
  input  sfr_pkg::desc_t   head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_frame_id,
  output logic [7:0]       out_control_value,
  output logic [7:0]       out_payload_value,
  output logic             out_has_payload,
  output logic             out_last_of_frame
);
  import sfr_pkg::*;

  logic [7:0] pay_mem [MEM_DEPTH];

  back_state_t state_r, state_nxt;
  logic [PAY_AW-1:0] idx_r, idx_nxt;
  logic rd_bank_r, rd_bank_nxt;
  logic [7:0] rdata_r;

  logic [3:0] len;
  logic last;

  assign len = head.ctrl[3:0];
  assign last = (len == 4'd0) || (idx_r == len - 4'd1);

  // payload buffer: one bank per frame, front fills one while we drain the other
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      pay_mem[{mem_wr.bank, mem_wr.addr}] <= mem_wr.data;
    end
    if (state_r == BK_FETCH) begin
      rdata_r <= pay_mem[{rd_bank_r, idx_r}];
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    rd_bank_nxt = rd_bank_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_FETCH;
          idx_nxt = '0;
        end
      end
      BK_FETCH: begin
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (!out_stall) begin
          if (last) begin
            state_nxt = BK_IDLE;
            rd_bank_nxt = !rd_bank_r;
          end else begin
            state_nxt = BK_FETCH;
            idx_nxt = idx_r + PAY_AW'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid = (state_r == BK_SHOW);
    pop = (state_r == BK_SHOW) && !out_stall && last;
    out_frame_id = head.ident;
    out_control_value = head.ctrl;
    out_has_payload = (len != 4'd0);
    out_payload_value = (len != 4'd0) ? rdata_r : 8'h00;
    out_last_of_frame = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      rd_bank_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_bank_r <= rd_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  show_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SHOW) |-> q_valid)
    else $error("result shown with no frame queued");

  stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SHOW) && out_stall |=> (state_r == BK_SHOW) && $stable(idx_r))
    else $error("result index moved while output stalled");

  no_write_into_read_bank: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en && (state_r != BK_IDLE) |-> (mem_wr.bank != rd_bank_r))
    else $error("payload written into the bank being delivered");

endmodule

>>> sv/stuffed_frame_receiver_fletcher16_unit.sv
// byte-stuffed frame receiver with fletcher-16 check
//
// input channel: one link byte per item on in_byte (in_valid / in_stall).
// three 0xaa bytes start a frame; inside a frame 0xaa 0xaa 0x55 drops the
// stuff byte. body is id, control (low nibble = payload length), payload,
// big-endian fletcher-16 over id/control/payload, then a 0x55 end byte.
// result channel: one item per payload byte (one item for an empty frame),
// carrying id, control, the byte, has_payload and last_of_frame.
// bad frames give no items at all.
// input side takes one byte per cycle while in_stall is low. the byte parser
// hands finished frames to a two-entry queue; payload bytes sit in a two-bank
// buffer, so in_stall rises only while the queue holds two good frames not yet
// fully delivered. once the end byte is taken the frame is queued, and each
// result is read from the payload buffer and then shown on the output.
// out_stall holds the current result unchanged; the parser keeps running
// until the queue fills.
// synchronous reset (rst_n low) returns to searching for a header and
// empties the queue; stored payload is not cleared.
module stuffed_frame_receiver_fletcher16_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_id,
  output logic [7:0] out_control_value,
  output logic [7:0] out_payload_value,
  output logic       out_has_payload,
  output logic       out_last_of_frame
);
  import sfr_pkg::*;

  mem_wr_t mem_wr;
  desc_t push_desc;
  desc_t head;
  logic push;
  logic pop;
  logic q_valid;
  logic q_full;

  assign in_stall = q_full;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_stall  (in_stall),
    .mem_wr    (mem_wr),
    .push      (push),
    .push_desc (push_desc)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  sfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_wr            (mem_wr),
    .q_valid           (q_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_id      (out_frame_id),
    .out_control_value (out_control_value),
    .out_payload_value (out_payload_value),
    .out_has_payload   (out_has_payload),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

>>> bench/stuffed_frame_receiver_fletcher16_unit_tb.sv
`timescale 1ns / 1ps

module stuffed_frame_receiver_fletcher16_unit_tb;
  import sfr_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_TAIL = 40;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [7:0] control;
    logic [7:0] payload;
    logic       has_payload;
    logic       last;
  } rx_result_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_CHECK,
    FLAW_END,
    FLAW_ABORT
  } flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_frame_id;
  logic [7:0] out_control_value;
  logic [7:0] out_payload_value;
  logic       out_has_payload;
  logic       out_last_of_frame;

  stuffed_frame_receiver_fletcher16_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_id      (out_frame_id),
    .out_control_value (out_control_value),
    .out_payload_value (out_payload_value),
    .out_has_payload   (out_has_payload),
    .out_last_of_frame (out_last_of_frame)
  );

  always #5 clk = ~clk;

  // predicted deframer state
  logic [1:0]  pr_run = 2'd0;
  phase_t      pr_phase = PH_SEARCH;
  logic [7:0]  pr_id = 8'h00;
  logic [7:0]  pr_ctrl = 8'h00;
  logic [3:0]  pr_left = 4'd0;
  logic [3:0]  pr_count = 4'd0;
  logic [15:0] pr_sum_lo = 16'h0000;
  logic [15:0] pr_sum_hi = 16'h0000;
  logic [15:0] pr_rx_check = 16'h0000;
  logic [7:0]  pr_store [PAYLOAD_DEPTH];

  rx_result_t expected_results [$];

  // frame encoder
  logic [7:0] link_q [$];
  logic [1:0] enc_run = 2'd0;
  logic [7:0] pay_buf [PAYLOAD_DEPTH];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int frames_built = 0;
  int results_seen = 0;

  function automatic rx_result_t make_result(input logic [7:0] id, input logic [7:0] ctrl,
                                             input logic [7:0] pay, input logic has,
                                             input logic last);
    rx_result_t r;
    r.frame_id = id;
    r.control = ctrl;
    r.payload = pay;
    r.has_payload = has;
    r.last = last;
    return r;
  endfunction

  task automatic add_to_sums(input logic [7:0] b);
    pr_sum_lo = pr_sum_lo + {8'h00, b};
    pr_sum_hi = pr_sum_hi + pr_sum_lo;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [15:0] lo_f;
    logic [15:0] hi_f;
    logic [15:0] calc;
    int len;
    if (pr_run == HDR_RUN_FULL) begin
      // third byte after two 0xaa: header, stuff byte or abort
      pr_run = 2'd0;
      if (b == HDR_BYTE) begin
        pr_phase = PH_ID;
      end else if (b != PAD_BYTE) begin
        pr_phase = PH_SEARCH;
      end
    end else begin
      if (b == HDR_BYTE) begin
        pr_run = pr_run + 2'd1;
      end else begin
        pr_run = 2'd0;
      end
      case (pr_phase)
        PH_ID: begin
          pr_id = b;
          pr_count = 4'd0;
          pr_sum_lo = SUM_INIT;
          pr_sum_hi = SUM_INIT;
          add_to_sums(b);
          pr_phase = PH_CTRL;
        end
        PH_CTRL: begin
          pr_ctrl = b;
          pr_left = b[3:0];
          add_to_sums(b);
          if (pr_left != 4'd0) begin
            pr_phase = PH_PAY;
          end else begin
            pr_phase = PH_CKH;
          end
        end
        PH_PAY: begin
          pr_store[pr_count] = b;
          pr_count = pr_count + 4'd1;
          add_to_sums(b);
          pr_left = pr_left - 4'd1;
          if (pr_left == 4'd0) begin
            pr_phase = PH_CKH;
          end
        end
        PH_CKH: begin
          pr_rx_check = {b, 8'h00};
          pr_phase = PH_CKL;
        end
        PH_CKL: begin
          pr_rx_check[7:0] = b;
          lo_f = {8'h00, pr_sum_lo[7:0]} + {8'h00, pr_sum_lo[15:8]};
          hi_f = {8'h00, pr_sum_hi[7:0]} + {8'h00, pr_sum_hi[15:8]};
          calc = (hi_f << 8) | lo_f;
          if (pr_rx_check == calc) begin
            pr_phase = PH_END;
          end else begin
            pr_phase = PH_SEARCH;
          end
        end
        PH_END: begin
          if (b == END_BYTE) begin
            len = int'(pr_ctrl & LEN_MASK);
            if (len == 0) begin
              expected_results.push_back(make_result(pr_id, pr_ctrl, 8'h00, 1'b0, 1'b1));
            end else begin
              for (int k = 0; k < len; k++) begin
                expected_results.push_back(make_result(pr_id, pr_ctrl, pr_store[k], 1'b1,
                                                       k == len - 1));
              end
            end
          end
          pr_phase = PH_SEARCH;
        end
        default: pr_phase = PH_SEARCH;
      endcase
    end
  endtask

  // check value the sender puts on the wire
  function automatic logic [15:0] frame_check(input logic [7:0] id, input logic [7:0] ctrl);
    logic [15:0] a;
    logic [15:0] c;
    a = SUM_INIT + {8'h00, id};
    c = SUM_INIT + a;
    a = a + {8'h00, ctrl};
    c = c + a;
    for (int k = 0; k < int'(ctrl[3:0]); k++) begin
      a = a + {8'h00, pay_buf[k]};
      c = c + a;
    end
    return {c[7:0] + c[15:8], 8'h00} | ({8'h00, a[7:0]} + {8'h00, a[15:8]});
  endfunction

  function automatic logic [7:0] rand_link_byte();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick < 2) begin
      return HDR_BYTE;
    end else if (pick == 2) begin
      return PAD_BYTE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_stuffed(input logic [7:0] b);
    link_q.push_back(b);
    if (b == HDR_BYTE) begin
      enc_run = enc_run + 2'd1;
      if (enc_run == 2'd2) begin
        link_q.push_back(PAD_BYTE);
        enc_run = 2'd0;
      end
    end else begin
      enc_run = 2'd0;
    end
  endtask

  task automatic build_frame(input logic [7:0] id, input logic [7:0] ctrl, input flaw_t flaw);
    logic [15:0] ck;
    logic [7:0]  body [$];
    logic [7:0]  tail;
    logic [7:0]  junk;
    int cut;
    ck = frame_check(id, ctrl);
    if (flaw == FLAW_CHECK) begin
      ck = ck ^ (16'h0001 << $urandom_range(0, 15));
    end
    body.push_back(id);
    body.push_back(ctrl);
    for (int k = 0; k < int'(ctrl[3:0]); k++) begin
      body.push_back(pay_buf[k]);
    end
    body.push_back(ck[15:8]);
    body.push_back(ck[7:0]);
    tail = END_BYTE;
    if (flaw == FLAW_END) begin
      tail = 8'($urandom_range(0, 255));
      if (tail == END_BYTE) begin
        tail = 8'h54;
      end
    end
    cut = -1;
    if (flaw == FLAW_ABORT) begin
      cut = $urandom_range(0, body.size());
    end
    repeat (3) link_q.push_back(HDR_BYTE);
    enc_run = 2'd0;
    for (int k = 0; k <= body.size(); k++) begin
      if (k == cut) begin
        // unstuffed pair followed by a byte that is neither header nor stuff
        junk = 8'($urandom_range(0, 255));
        if (junk == HDR_BYTE || junk == PAD_BYTE) begin
          junk = 8'h00;
        end
        // a pending 0xaa already counts toward the pair
        if (enc_run == 2'd0) begin
          link_q.push_back(HDR_BYTE);
        end
        link_q.push_back(HDR_BYTE);
        link_q.push_back(junk);
        enc_run = 2'd0;
      end
      if (k < body.size()) begin
        push_stuffed(body[k]);
      end else begin
        push_stuffed(tail);
      end
    end
    frames_built++;
  endtask

  task automatic fill_payload(input int len);
    for (int k = 0; k < len; k++) begin
      pay_buf[k] = rand_link_byte();
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_link();
    while (link_q.size() != 0) begin
      send_byte(link_q.pop_front());
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < 40) begin
      $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_result();
    rx_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("item with nothing expected", out_frame_id, 8'h00);
    end else begin
      want = expected_results.pop_front();
      if (out_frame_id !== want.frame_id)
        report_mismatch("frame_id", out_frame_id, want.frame_id);
      if (out_control_value !== want.control)
        report_mismatch("control_value", out_control_value, want.control);
      if (out_payload_value !== want.payload)
        report_mismatch("payload_value", out_payload_value, want.payload);
      if (out_has_payload !== want.has_payload)
        report_mismatch("has_payload", {7'd0, out_has_payload}, {7'd0, want.has_payload});
      if (out_last_of_frame !== want.last)
        report_mismatch("last_of_frame", {7'd0, out_last_of_frame}, {7'd0, want.last});
    end
  endtask

  // result side: check, then choose next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result();
    end
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL stuffed_frame_receiver_fletcher16_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    send_gap_pct = 21;
    recv_gap_pct = 52;
    // empty frame with reserved nibble set
    build_frame(8'h00, 8'hF0, FLAW_NONE);
    // longest frame, stuffing inside payload
    for (int k = 0; k < PAYLOAD_DEPTH; k++) begin
      pay_buf[k] = 8'(k * 17);
    end
    pay_buf[0] = 8'h00;
    pay_buf[1] = 8'hFF;
    pay_buf[2] = HDR_BYTE;
    pay_buf[3] = HDR_BYTE;
    pay_buf[4] = HDR_BYTE;
    pay_buf[5] = PAD_BYTE;
    build_frame(8'hFF, 8'h0F, FLAW_NONE);
    // header byte value as id and as the first payload byte
    pay_buf[0] = HDR_BYTE;
    build_frame(HDR_BYTE, 8'hA1, FLAW_NONE);
    send_link();
    wait_idle();
  endtask

  task automatic test_special_cases();
    logic [7:0] fid;
    bit found;
    fid = 8'h00;
    found = 0;
    fill_payload(2);
    build_frame(8'h31, 8'h52, FLAW_CHECK);
    build_frame(8'h32, 8'h02, FLAW_END);
    build_frame(8'h33, 8'h62, FLAW_ABORT);
    // check of 0xaaaa: stuff byte lands in the end-byte phase
    for (int i = 0; i < 256 && !found; i++) begin
      for (int j = 0; j < 256 && !found; j++) begin
        pay_buf[0] = j[7:0];
        if (frame_check(i[7:0], 8'h01) == {HDR_BYTE, HDR_BYTE}) begin
          found = 1;
          fid = i[7:0];
        end
      end
    end
    build_frame(fid, 8'h01, FLAW_NONE);
    build_frame(fid, 8'h01, FLAW_END);
    // new header in the middle of a payload
    link_q.push_back(HDR_BYTE);
    link_q.push_back(HDR_BYTE);
    link_q.push_back(HDR_BYTE);
    link_q.push_back(8'h21);
    link_q.push_back(8'h03);
    link_q.push_back(8'h11);
    pay_buf[0] = 8'h7E;
    build_frame(8'h22, 8'h01, FLAW_NONE);
    // stuffed pair while searching is not a header
    link_q.push_back(HDR_BYTE);
    link_q.push_back(HDR_BYTE);
    link_q.push_back(PAD_BYTE);
    link_q.push_back(HDR_BYTE);
    link_q.push_back(8'h12);
    build_frame(8'h44, 8'h80, FLAW_NONE);
    send_link();
    wait_idle();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int target);
    int start;
    int pick;
    int len;
    logic [7:0] ctrl;
    flaw_t flaw;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 6)) link_q.push_back(rand_link_byte());
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          len = $urandom_range(0, 15);
        end else begin
          len = $urandom_range(0, 4);
        end
        ctrl = 8'($urandom_range(0, 255));
        ctrl[3:0] = len[3:0];
        fill_payload(len);
        if (pick < 70) flaw = FLAW_NONE;
        else if (pick < 78) flaw = FLAW_CHECK;
        else if (pick < 86) flaw = FLAW_END;
        else flaw = FLAW_ABORT;
        build_frame(8'($urandom_range(0, 255)), ctrl, flaw);
      end
      send_link();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    // receiver holds off while good frames keep coming
    hold_requests = hold_requests + 1;
    repeat (4) begin
      fill_payload(3);
      build_frame(8'($urandom_range(0, 255)), 8'h03, FLAW_NONE);
    end
    send_link();
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_special_cases();
    test_random(21, 52, 65);
    test_random(52, 21, 65);
    test_random(0, 0, 65);
    test_backpressure();
    $display("sent %0d link bytes in %0d frames, checked %0d result items, %0d mismatches",
             bytes_sent, frames_built, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS stuffed_frame_receiver_fletcher16_unit");
    end else begin
      $display("FAIL stuffed_frame_receiver_fletcher16_unit");
    end
    $finish;
  end

endmodule
